### design/compressed_token_bit_parser_assert.svh
// Assertion macros used by the compressed token bit parser core (ctbp_core).
// Expects clk_i and rst_ni in the scope of each use.
`ifndef COMPRESSED_TOKEN_BIT_PARSER_ASSERT_SVH
`define COMPRESSED_TOKEN_BIT_PARSER_ASSERT_SVH

// same-cycle implication
`define CTBP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ctbp: same-cycle check failed");

// next-cycle implication
`define CTBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ctbp: next-cycle check failed");

`endif

### design/ctbp_pkg.sv
// Package for the compressed token bit parser: word types, register
// indexes, token kinds and parse phase codes. No dependencies.
package ctbp_pkg;

  localparam int unsigned MAX_FIELD_BITS_DEF = 16;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned REG_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_CLASS0_CODE_BITS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS1_CODE_BITS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLASS2_CODE_BITS = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_COUNT_BITS   = 8'd3;

  localparam logic [REG_W-1:0] CLASS0_RESET = 5'd4;
  localparam logic [REG_W-1:0] CLASS1_RESET = 5'd8;
  localparam logic [REG_W-1:0] CLASS2_RESET = 5'd12;
  localparam logic [REG_W-1:0] RUN_RESET    = 5'd0;

  localparam logic [2:0] KIND_LITERAL  = 3'd0;
  localparam logic [2:0] KIND_UNIFORM  = 3'd1;
  localparam logic [2:0] KIND_RAMP     = 3'd2;
  localparam logic [2:0] KIND_CODE     = 3'd3;
  localparam logic [2:0] KIND_CLEAN    = 3'd4;
  localparam logic [2:0] KIND_TRUNC    = 3'd5;
  localparam logic [2:0] KIND_BAD_RAMP = 3'd6;

  localparam logic [3:0] PH_PREFIX  = 4'd0;
  localparam logic [3:0] PH_LITERAL = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_FLAG    = 4'd3;
  localparam logic [3:0] PH_COUNT   = 4'd4;
  localparam logic [3:0] PH_RUNBYTE = 4'd5;
  localparam logic [3:0] PH_RSTART  = 4'd6;
  localparam logic [3:0] PH_REND    = 4'd7;
  localparam logic [3:0] PH_CODE    = 4'd8;

  localparam logic [1:0] CLASS_EXT = 2'd3;

  typedef struct packed {
    logic operation;
    logic bit_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [7:0]  first_byte;
    logic [7:0]  last_byte;
    logic [15:0] run_length;
    logic [1:0]  code_class_out;
    logic [15:0] code_value;
  } out_word_t;

  typedef struct packed {
    logic [REG_W-1:0] class0_code_bits;
    logic [REG_W-1:0] class1_code_bits;
    logic [REG_W-1:0] class2_code_bits;
    logic [REG_W-1:0] run_count_bits;
  } cfg_t;

endpackage

### design/ctbp_cfg.sv
// Configuration registers of the compressed token bit parser.
// Depends on ctbp_pkg.
module ctbp_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [ctbp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ctbp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output ctbp_pkg::cfg_t                    cfg_o
);

  ctbp_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        ctbp_pkg::CFG_CLASS0_CODE_BITS: cfg_d.class0_code_bits = cfg_data_i[ctbp_pkg::REG_W-1:0];
        ctbp_pkg::CFG_CLASS1_CODE_BITS: cfg_d.class1_code_bits = cfg_data_i[ctbp_pkg::REG_W-1:0];
        ctbp_pkg::CFG_CLASS2_CODE_BITS: cfg_d.class2_code_bits = cfg_data_i[ctbp_pkg::REG_W-1:0];
        ctbp_pkg::CFG_RUN_COUNT_BITS:   cfg_d.run_count_bits   = cfg_data_i[ctbp_pkg::REG_W-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.class0_code_bits <= ctbp_pkg::CLASS0_RESET;
      cfg_q.class1_code_bits <= ctbp_pkg::CLASS1_RESET;
      cfg_q.class2_code_bits <= ctbp_pkg::CLASS2_RESET;
      cfg_q.run_count_bits   <= ctbp_pkg::RUN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### design/ctbp_core.sv
// Parse state machine of the compressed token bit parser: takes one stream
// word per go_i and forms at most one result. Depends on ctbp_pkg.
`include "compressed_token_bit_parser_assert.svh"

module ctbp_core #(
  parameter int unsigned MAX_FIELD_BITS = ctbp_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctbp_pkg::cfg_t      cfg_i,
  input  logic                go_i,
  input  ctbp_pkg::in_word_t  word_i,
  output logic                res_valid_o,
  output ctbp_pkg::out_word_t res_o
);

  localparam int unsigned LeftW = $clog2(MAX_FIELD_BITS + 1);

  logic [3:0]                phase_d, phase_q;
  logic [MAX_FIELD_BITS-1:0] shift_d, shift_q;
  logic [LeftW-1:0]          left_d, left_q;
  logic [1:0]                class_d, class_q;
  logic [15:0]               count_d, count_q;
  logic [7:0]                byte_d, byte_q;
  logic                      halted_d, halted_q;

  logic [MAX_FIELD_BITS-1:0] shifted;
  logic [31:0]               v32;
  logic [LeftW-1:0]          left_dec;
  logic [ctbp_pkg::REG_W-1:0] code_w_raw;
  logic [LeftW-1:0]          code_w;
  logic [LeftW-1:0]          run_w;
  logic                      error_word;

  function automatic logic [LeftW-1:0] clamp_w(input logic [ctbp_pkg::REG_W-1:0] w);
    if (32'(w) > MAX_FIELD_BITS) begin
      clamp_w = LeftW'(MAX_FIELD_BITS);
    end else begin
      clamp_w = LeftW'(w);
    end
  endfunction

  if (MAX_FIELD_BITS > 1) begin : g_shift
    assign shifted = {shift_q[MAX_FIELD_BITS-2:0], word_i.bit_value};
  end else begin : g_shift1
    assign shifted = word_i.bit_value;
  end

  assign v32      = 32'(shifted);
  assign left_dec = left_q - LeftW'(1);

  always_comb begin
    case (shifted[1:0])
      2'd0:    code_w_raw = cfg_i.class0_code_bits;
      2'd1:    code_w_raw = cfg_i.class1_code_bits;
      default: code_w_raw = cfg_i.class2_code_bits;
    endcase
  end

  assign code_w = clamp_w(code_w_raw);
  assign run_w  = (cfg_i.run_count_bits == '0) ? LeftW'(8) : clamp_w(cfg_i.run_count_bits);

  always_comb begin
    phase_d     = phase_q;
    shift_d     = shift_q;
    left_d      = left_q;
    class_d     = class_q;
    count_d     = count_q;
    byte_d      = byte_q;
    halted_d    = halted_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (go_i && !halted_q) begin
      if (word_i.operation) begin
        phase_d     = ctbp_pkg::PH_PREFIX;
        shift_d     = '0;
        left_d      = '0;
        res_valid_o = 1'b1;
        if (phase_q == ctbp_pkg::PH_PREFIX || phase_q == ctbp_pkg::PH_LITERAL) begin
          res_o.token_kind = ctbp_pkg::KIND_CLEAN;
        end else begin
          res_o.token_kind = ctbp_pkg::KIND_TRUNC;
          halted_d         = 1'b1;
        end
      end else if (phase_q == ctbp_pkg::PH_PREFIX) begin
        shift_d = '0;
        if (word_i.bit_value) begin
          phase_d = ctbp_pkg::PH_CLASS;
          left_d  = LeftW'(2);
        end else begin
          phase_d = ctbp_pkg::PH_LITERAL;
          left_d  = LeftW'(8);
        end
      end else if (phase_q > ctbp_pkg::PH_CODE || left_q == '0) begin
        phase_d = ctbp_pkg::PH_PREFIX;
        shift_d = '0;
        left_d  = '0;
      end else if (left_dec != '0) begin
        shift_d = shifted;
        left_d  = left_dec;
      end else begin
        shift_d = '0;
        phase_d = ctbp_pkg::PH_PREFIX;
        left_d  = '0;
        case (phase_q)
          ctbp_pkg::PH_LITERAL: begin
            res_valid_o      = 1'b1;
            res_o.token_kind = ctbp_pkg::KIND_LITERAL;
            res_o.first_byte = v32[7:0];
          end
          ctbp_pkg::PH_CLASS: begin
            class_d = shifted[1:0];
            if (shifted[1:0] == ctbp_pkg::CLASS_EXT) begin
              phase_d = ctbp_pkg::PH_FLAG;
              left_d  = LeftW'(1);
            end else if (code_w == '0) begin
              res_valid_o          = 1'b1;
              res_o.token_kind     = ctbp_pkg::KIND_CODE;
              res_o.code_class_out = shifted[1:0];
            end else begin
              phase_d = ctbp_pkg::PH_CODE;
              left_d  = code_w;
            end
          end
          ctbp_pkg::PH_FLAG: begin
            if (word_i.bit_value) begin
              phase_d = ctbp_pkg::PH_COUNT;
              left_d  = run_w;
            end else begin
              phase_d = ctbp_pkg::PH_RSTART;
              left_d  = LeftW'(8);
            end
          end
          ctbp_pkg::PH_COUNT: begin
            count_d = v32[15:0];
            phase_d = ctbp_pkg::PH_RUNBYTE;
            left_d  = LeftW'(8);
          end
          ctbp_pkg::PH_RUNBYTE: begin
            res_valid_o      = 1'b1;
            res_o.token_kind = ctbp_pkg::KIND_UNIFORM;
            res_o.first_byte = v32[7:0];
            res_o.run_length = count_q;
          end
          ctbp_pkg::PH_RSTART: begin
            byte_d  = v32[7:0];
            phase_d = ctbp_pkg::PH_REND;
            left_d  = LeftW'(8);
          end
          ctbp_pkg::PH_REND: begin
            res_valid_o      = 1'b1;
            res_o.first_byte = byte_q;
            res_o.last_byte  = v32[7:0];
            if (v32[7:0] < byte_q) begin
              res_o.token_kind = ctbp_pkg::KIND_BAD_RAMP;
              halted_d         = 1'b1;
            end else begin
              res_o.token_kind = ctbp_pkg::KIND_RAMP;
            end
          end
          ctbp_pkg::PH_CODE: begin
            res_valid_o          = 1'b1;
            res_o.token_kind     = ctbp_pkg::KIND_CODE;
            res_o.code_class_out = class_q;
            res_o.code_value     = v32[15:0];
          end
          default: phase_d = ctbp_pkg::PH_PREFIX;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ctbp_pkg::PH_PREFIX;
      shift_q  <= '0;
      left_q   <= '0;
      class_q  <= '0;
      count_q  <= '0;
      byte_q   <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      left_q   <= left_d;
      class_q  <= class_d;
      count_q  <= count_d;
      byte_q   <= byte_d;
      halted_q <= halted_d;
    end
  end

  assign error_word = res_valid_o &&
                      (res_o.token_kind inside {ctbp_pkg::KIND_TRUNC, ctbp_pkg::KIND_BAD_RAMP});

  `CTBP_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q)
  `CTBP_ASSERT_NOW(a_halt_silent, halted_q, !res_valid_o)
  `CTBP_ASSERT_NEXT(a_error_halts, error_word, halted_q)
  `CTBP_ASSERT_NOW(a_prefix_idle, phase_q == ctbp_pkg::PH_PREFIX, left_q == '0)

endmodule

### design/compressed_token_bit_parser.sv
// Top level of the compressed token bit parser: input word register, parse
// core, result register and configuration registers.
// Depends on ctbp_pkg, ctbp_cfg and ctbp_core.

// Takes the compressed stream one bit per word, first bit of each field as
// its MSB, and gives one result word per finished token, per stream end and
// per error. A word passes input register, parse logic and result register;
// a new word is taken every cycle while the result side keeps up. The
// parse state machine is the only loop. After a truncated stream or a
// descending ramp the parser drops all words until reset. Configuration
// writes are taken at once and apply to the next field that starts.
module compressed_token_bit_parser #(
  parameter int unsigned MAX_FIELD_BITS = ctbp_pkg::MAX_FIELD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ctbp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ctbp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ctbp_pkg::in_word_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ctbp_pkg::out_word_t               out_data_o
);

  ctbp_pkg::cfg_t      cfg;
  ctbp_pkg::in_word_t  in_word_q;
  ctbp_pkg::out_word_t out_word_q, res;
  logic                in_valid_d, in_valid_q;
  logic                out_valid_d, out_valid_q;
  logic                advance, res_valid;

  assign cfg_ready_o = 1'b1;

  ctbp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  ctbp_core #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .go_i        (advance),
    .word_i      (in_word_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_data_i;
    end
    if (advance && res_valid) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

### verif/tb.sv
// Self-checking testbench for compressed_token_bit_parser: drives the bit stream and
// register writes through valid/ready channels and checks every result word against
// an in-bench parse model or a typed vector's expected word. Depends on ctbp_pkg and the parser RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctbp_pkg::*;

  localparam int unsigned MAX_W = MAX_FIELD_BITS_DEF;
  localparam int unsigned DEFAULT_RUN_W = 8;
  localparam logic OP_BIT = 1'b0;
  localparam logic OP_END = 1'b1;

  typedef struct packed {
    logic [39:0] bits;
    logic [5:0]  nbits;
    logic        eos;
    logic        typed;
    out_word_t   want;
  } vec_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  in_word_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_word_t             out_data_o;

  // parse model state and register copy
  logic [3:0]  parse_ph = PH_PREFIX;
  logic [15:0] field_val = '0;
  int unsigned bits_left = 0;
  logic [1:0]  held_cls = '0;
  logic [15:0] held_cnt = '0;
  logic [7:0]  ramp_start = '0;
  bit          halted = 1'b0;
  logic [4:0]  code_w [3] = '{CLASS0_RESET, CLASS1_RESET, CLASS2_RESET};
  logic [4:0]  run_w = RUN_RESET;

  out_word_t   tokens_due [$];
  vec_t        dir_vecs [$];
  bit          table_on = 1'b0;
  out_word_t   table_word = '0;
  int unsigned words_sent = 0;
  int unsigned words_taken = 0;
  int unsigned errors = 0;
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit          hold_start = 1'b0;

  compressed_token_bit_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic out_word_t token_word(logic [2:0] kind, logic [7:0] first,
                                           logic [7:0] last, logic [15:0] run,
                                           logic [1:0] cls, logic [15:0] code);
    out_word_t w;
    w.token_kind     = kind;
    w.first_byte     = first;
    w.last_byte      = last;
    w.run_length     = run;
    w.code_class_out = cls;
    w.code_value     = code;
    return w;
  endfunction

  function automatic int unsigned sat_width(logic [4:0] w);
    return (w > MAX_W) ? MAX_W : int'(w);
  endfunction

  function automatic int unsigned count_width();
    return (run_w == '0) ? DEFAULT_RUN_W : sat_width(run_w);
  endfunction

  function automatic logic [15:0] pick_bits();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic vec_t mk_vec(logic [39:0] bits, int unsigned n, bit eos, bit typed,
                                  out_word_t want);
    vec_t v;
    v.bits  = bits;
    v.nbits = 6'(n);
    v.eos   = eos;
    v.typed = typed;
    v.want  = want;
    return v;
  endfunction

  task automatic queue_token(out_word_t w);
    tokens_due.push_back(table_on ? table_word : w);
  endtask

  task automatic start_field(logic [3:0] ph, int unsigned w);
    parse_ph  = ph;
    field_val = '0;
    bits_left = w;
  endtask

  task automatic track_word(in_word_t w);
    logic [15:0] v;
    int unsigned cw;
    if (halted) return;
    if (w.operation == OP_END) begin
      if (parse_ph == PH_PREFIX || parse_ph == PH_LITERAL) begin
        queue_token(token_word(KIND_CLEAN, '0, '0, '0, '0, '0));
      end else begin
        halted = 1'b1;
        queue_token(token_word(KIND_TRUNC, '0, '0, '0, '0, '0));
      end
      start_field(PH_PREFIX, 0);
      return;
    end
    if (parse_ph == PH_PREFIX) begin
      if (w.bit_value) start_field(PH_CLASS, 2);
      else start_field(PH_LITERAL, 8);
      return;
    end
    if (bits_left == 0) begin
      start_field(PH_PREFIX, 0);
      return;
    end
    field_val = {field_val[14:0], w.bit_value};
    bits_left--;
    if (bits_left != 0) return;
    v = field_val;
    case (parse_ph)
      PH_LITERAL: begin
        start_field(PH_PREFIX, 0);
        queue_token(token_word(KIND_LITERAL, v[7:0], '0, '0, '0, '0));
      end
      PH_CLASS: begin
        held_cls = v[1:0];
        if (held_cls == CLASS_EXT) begin
          start_field(PH_FLAG, 1);
        end else begin
          cw = sat_width(code_w[held_cls]);
          if (cw == 0) begin
            start_field(PH_PREFIX, 0);
            queue_token(token_word(KIND_CODE, '0, '0, '0, held_cls, '0));
          end else begin
            start_field(PH_CODE, cw);
          end
        end
      end
      PH_FLAG: begin
        if (v[0]) start_field(PH_COUNT, count_width());
        else start_field(PH_RSTART, 8);
      end
      PH_COUNT: begin
        held_cnt = v;
        start_field(PH_RUNBYTE, 8);
      end
      PH_RUNBYTE: begin
        start_field(PH_PREFIX, 0);
        queue_token(token_word(KIND_UNIFORM, v[7:0], '0, held_cnt, '0, '0));
      end
      PH_RSTART: begin
        ramp_start = v[7:0];
        start_field(PH_REND, 8);
      end
      PH_REND: begin
        start_field(PH_PREFIX, 0);
        if (v[7:0] < ramp_start) begin
          halted = 1'b1;
          queue_token(token_word(KIND_BAD_RAMP, ramp_start, v[7:0], '0, '0, '0));
        end else begin
          queue_token(token_word(KIND_RAMP, ramp_start, v[7:0], '0, '0, '0));
        end
      end
      PH_CODE: begin
        start_field(PH_PREFIX, 0);
        queue_token(token_word(KIND_CODE, '0, '0, '0, held_cls, v));
      end
      default: start_field(PH_PREFIX, 0);
    endcase
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : watch_input
    if (rst_ni && in_valid_i && in_ready_o) begin
      track_word(in_data_i);
      words_taken++;
    end
  end

  always @(posedge clk_i) begin : check_tokens
    out_word_t got;
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = out_data_o;
      if (tokens_due.size() == 0) begin
        $display("%0t: expected no word, got %p", $time, got);
        errors++;
      end else begin
        want = tokens_due.pop_front();
        check_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
        check_field("first_byte", 16'(want.first_byte), 16'(got.first_byte));
        check_field("last_byte", 16'(want.last_byte), 16'(got.last_byte));
        check_field("run_length", want.run_length, got.run_length);
        check_field("code_class_out", 16'(want.code_class_out), 16'(got.code_class_out));
        check_field("code_value", want.code_value, got.code_value);
      end
    end
  end

  initial begin : drive_out_ready
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic push_word(in_word_t w);
    if ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic push_end();
    push_word('{operation: OP_END, bit_value: 1'($urandom)});
  endtask

  task automatic stream_bits(logic [39:0] v, int unsigned n);
    for (int i = n; i > 0; i--) push_word('{operation: OP_BIT, bit_value: v[i-1]});
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_CLASS0_CODE_BITS: code_w[0] = data[4:0];
      CFG_CLASS1_CODE_BITS: code_w[1] = data[4:0];
      CFG_CLASS2_CODE_BITS: code_w[2] = data[4:0];
      CFG_RUN_COUNT_BITS:   run_w = data[4:0];
      default: ;
    endcase
  endtask

  // drop valid, wait for every word to be taken and answered, then let the pipe empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (words_taken != words_sent || tokens_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] reg_value(int p);
    case (p)
      0: return 8'd0;
      1: return 8'd16;
      2: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random_token();
    int unsigned pick;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [1:0]  c;
    logic [15:0] v;
    pick = $urandom_range(99);
    a = 8'(pick_bits());
    v = pick_bits();
    if (pick < 30) begin
      stream_bits(40'({1'b0, a}), 9);
    end else if (pick < 45) begin
      stream_bits(40'({1'b1, CLASS_EXT, 1'b1}), 4);
      stream_bits(40'(v), count_width());
      stream_bits(40'(a), 8);
    end else if (pick < 60) begin
      b = 8'($urandom_range(255, a));
      stream_bits(40'({1'b1, CLASS_EXT, 1'b0, a, b}), 20);
    end else if (pick < 92) begin
      c = 2'($urandom_range(2));
      stream_bits(40'({1'b1, c}), 3);
      stream_bits(40'(v), sat_width(code_w[c]));
    end else if (pick < 96) begin
      push_end();
    end else begin
      // end the stream inside a literal byte
      push_word('{operation: OP_BIT, bit_value: 1'b0});
      stream_bits(40'(v), 1 + $urandom_range(6));
      push_end();
    end
  endtask

  initial begin : run_stream
    int unsigned mark;
    logic [7:0]  a;
    logic [7:0]  b;
    int unsigned cut;

    dir_vecs.push_back(mk_vec('0, 0, 1'b1, 1'b1,
                              token_word(KIND_CLEAN, '0, '0, '0, '0, '0)));
    dir_vecs.push_back(mk_vec(40'({1'b0, 8'h00}), 9, 1'b0, 1'b1,
                              token_word(KIND_LITERAL, 8'h00, '0, '0, '0, '0)));
    dir_vecs.push_back(mk_vec(40'({1'b0, 8'hFF}), 9, 1'b0, 1'b1,
                              token_word(KIND_LITERAL, 8'hFF, '0, '0, '0, '0)));
    dir_vecs.push_back(mk_vec(40'({1'b0, 8'hA5}), 9, 1'b0, 1'b0, '0));
    dir_vecs.push_back(mk_vec(40'({1'b1, CLASS_EXT, 1'b1, 8'hFF, 8'h00}), 20, 1'b0, 1'b1,
                              token_word(KIND_UNIFORM, 8'h00, '0, 16'd255, '0, '0)));
    dir_vecs.push_back(mk_vec(40'({1'b1, CLASS_EXT, 1'b1, 8'h00, 8'hFF}), 20, 1'b0, 1'b1,
                              token_word(KIND_UNIFORM, 8'hFF, '0, '0, '0, '0)));
    dir_vecs.push_back(mk_vec(40'({1'b1, CLASS_EXT, 1'b1, 8'h3C, 8'h81}), 20, 1'b0, 1'b0,
                              '0));
    dir_vecs.push_back(mk_vec(40'({1'b1, CLASS_EXT, 1'b0, 8'h00, 8'hFF}), 20, 1'b0, 1'b1,
                              token_word(KIND_RAMP, 8'h00, 8'hFF, '0, '0, '0)));
    dir_vecs.push_back(mk_vec(40'({1'b1, CLASS_EXT, 1'b0, 8'h5A, 8'h5A}), 20, 1'b0, 1'b0,
                              '0));
    dir_vecs.push_back(mk_vec(40'({1'b1, 2'd0, 4'hF}), 7, 1'b0, 1'b1,
                              token_word(KIND_CODE, '0, '0, '0, 2'd0, 16'h000F)));
    dir_vecs.push_back(mk_vec(40'({1'b1, 2'd1, 8'h00}), 11, 1'b0, 1'b0, '0));
    dir_vecs.push_back(mk_vec(40'({1'b1, 2'd2, 12'hFFF}), 15, 1'b0, 1'b1,
                              token_word(KIND_CODE, '0, '0, '0, 2'd2, 16'h0FFF)));
    dir_vecs.push_back(mk_vec(40'({1'b1, 2'd2, 12'h5A3}), 15, 1'b0, 1'b0, '0));
    dir_vecs.push_back(mk_vec(40'({1'b0, 3'b101}), 4, 1'b1, 1'b1,
                              token_word(KIND_CLEAN, '0, '0, '0, '0, '0)));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle = 21;
    recv_idle = 74;
    foreach (dir_vecs[r]) begin
      table_on   = dir_vecs[r].typed;
      table_word = dir_vecs[r].want;
      stream_bits(dir_vecs[r].bits, int'(dir_vecs[r].nbits));
      if (dir_vecs[r].eos) push_end();
      settle();
    end
    table_on = 1'b0;

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          send_idle = 21;
          recv_idle = 74;
        end
        1: begin
          send_idle = 74;
          recv_idle = 21;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_reg(CFG_CLASS0_CODE_BITS, reg_value(p));
      write_reg(CFG_CLASS1_CODE_BITS, reg_value(p));
      write_reg(CFG_CLASS2_CODE_BITS, reg_value(p));
      write_reg(CFG_RUN_COUNT_BITS, reg_value(p));
      write_reg(8'($urandom_range(255, CFG_RUN_COUNT_BITS + 1)), 8'($urandom));
      cfg_valid_i <= 1'b0;
      mark = words_sent;
      if (p == 4) begin
        hold_start = 1'b1;
        repeat (24) push_end();
      end
      while (words_sent - mark < 205) send_random_token();
      settle();
    end

    // end on an error, then feed words the halted parser must drop
    a = 8'($urandom_range(255, 1));
    if ($urandom_range(1) == 1) begin
      b   = 8'($urandom);
      cut = $urandom_range(19, 1);
      stream_bits(40'({1'b1, CLASS_EXT, 1'b0, a, b}) >> (20 - cut), cut);
      push_end();
    end else begin
      b = 8'($urandom_range(a - 1, 0));
      stream_bits(40'({1'b1, CLASS_EXT, 1'b0, a, b}), 20);
    end
    repeat (40) push_word('{operation: 1'($urandom), bit_value: 1'($urandom)});
    settle();
    repeat (8) @(posedge clk_i);

    if (errors == 0) begin
      $display("compressed_token_bit_parser regression: pass");
    end else begin
      $display("compressed_token_bit_parser regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("compressed_token_bit_parser regression: fail");
    $finish;
  end

endmodule
